// ----- rtl/core/mh2_pkg.sv -----
// Shared constants and types for the MurmurHash2 32-bit hash block.
// No dependencies; imported by the core and by its checker.
package mh2_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned LengthW = 31;
  localparam int unsigned InDataW = 72;  // 32 + 3 + 31 fields, padded to whole bytes
  localparam int unsigned AddrW   = 3;

  localparam logic [HashW-1:0]  MixMul   = 32'h5bd1_e995;
  localparam logic [HashW-1:0]  SeedRst  = 32'd97;
  localparam logic [CountW-1:0] FullWord = 3'd4;

  // Byte address of the seed register.
  localparam logic [AddrW-1:0] AddrSeed = 3'd0;

  typedef logic [HashW-1:0] word_t;

endpackage

// ----- rtl/core/murmur2_hash_32.sv -----
// Streaming 32-bit MurmurHash2 core with an APB seed register.
// Depends on mh2_pkg for constants and the word type.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid_i/tready_o     tdata: data_word, byte_count, message_length
//                                               tuser: first_item  tlast: last_item
//   m_axis    out  m_axis_tvalid_o/tready_i     tdata: hash_value
//   apb       in   psel/penable/pwrite/pready   paddr, pwdata, prdata: hash_seed at 0x0
//
// A full four-byte word is accepted, then makes three passes through the single
// shared constant multiplier (k*m, mixed k*m, h*m). A tail is accepted and makes one
// extra multiplier pass, (h ^ tail) * m; a short non-last item is finished in its accept cycle.
// The last item adds an avalanche step, which waits while a previous result is
// still held in the output register. Reset is asynchronous, active low; it loads the
// seed with 97 and clears the running hash. The input side is not ready while an
// item is being worked on.
module murmur2_hash_32
  import mh2_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [31:0] data_word, [34:32] byte_count, [65:35] message_length, [71:66] zero
  input  logic [InDataW-1:0]   s_axis_tdata_i,
  // [0] first_item
  input  logic                 s_axis_tuser_i,
  input  logic                 s_axis_tlast_i,
  // result items
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [31:0] hash_value
  output logic [HashW-1:0]     m_axis_tdata_o,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [HashW-1:0]     pwdata,
  output logic [HashW-1:0]     prdata,
  output logic                 pready
);

  // Sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StK1   = 3'd1;  // k = k * m
  localparam logic [2:0] StK2   = 3'd2;  // k = (k ^ k >> 24) * m
  localparam logic [2:0] StH    = 3'd3;  // h = h * m ^ k
  localparam logic [2:0] StTail = 3'd4;  // h = (h ^ tail) * m
  localparam logic [2:0] StAva  = 3'd5;  // out = avalanche(h)

  logic [2:0]  state_q, state_d;
  word_t       hash_q, hash_d;    // running hash, kept pre-avalanche
  word_t       key_q, key_d;
  logic        last_q, last_d;
  word_t       seed_q;
  logic        out_valid_q, out_valid_d;
  word_t       out_data_q, out_data_d;

  // Unpack the input item
  word_t              in_word;
  logic [CountW-1:0]  in_count_raw, in_count;
  logic [LengthW-1:0] in_length;
  word_t              in_hash;
  word_t              tail_mask;
  logic               in_accept;

  assign in_word      = s_axis_tdata_i[31:0];
  assign in_count_raw = s_axis_tdata_i[34:32];
  assign in_length    = s_axis_tdata_i[65:35];
  // counts above four saturate to a full word
  assign in_count     = in_count_raw[2] ? FullWord : in_count_raw;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Seed with the length on the first item, else carry on from the running hash
  assign in_hash = s_axis_tuser_i ? (seed_q ^ {1'b0, in_length}) : hash_q;

  always_comb begin
    case (in_count)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  // The one shared multiplier; its operand is chosen by the sequencer
  word_t mul_a;
  word_t mul_p;
  logic [2*HashW-1:0] mul_full;

  always_comb begin
    case (state_q)
      StK1:    mul_a = key_q;
      StK2:    mul_a = key_q ^ (key_q >> 24);
      StH:     mul_a = hash_q;
      StTail:  mul_a = hash_q ^ key_q;
      StAva:   mul_a = hash_q ^ (hash_q >> 13);
      default: mul_a = key_q;
    endcase
  end

  assign mul_full = mul_a * MixMul;
  assign mul_p    = mul_full[HashW-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    key_d       = key_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // drop the result once taken
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          hash_d = in_hash;
          last_d = s_axis_tlast_i;
          if (in_count == FullWord) begin
            key_d   = in_word;
            state_d = StK1;
          end else if (s_axis_tlast_i && (in_count != '0)) begin
            key_d   = in_word & tail_mask;
            state_d = StTail;
          end else if (s_axis_tlast_i) begin
            state_d = StAva;
          end
        end
      end
      StK1: begin
        key_d   = mul_p;
        state_d = StK2;
      end
      StK2: begin
        key_d   = mul_p;
        state_d = StH;
      end
      StH: begin
        hash_d  = mul_p ^ key_q;
        state_d = last_q ? StAva : StIdle;
      end
      StTail: begin
        hash_d  = mul_p;
        state_d = StAva;
      end
      StAva: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = mul_p ^ (mul_p >> 15);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Configuration: the seed register sits at byte address 0
  logic seed_sel;
  assign seed_sel = (paddr[AddrW-1:2] == AddrSeed[AddrW-1:2]);
  assign pready   = 1'b1;
  assign prdata   = seed_sel ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedRst;
    end else if (psel && penable && pwrite && pready && seed_sel) begin
      seed_q <= pwdata;
    end
  end

endmodule

// ----- rtl/core/mh2_checker.sv -----
// Port-level checker for the MurmurHash2 core, bound to its top level.
// Depends on mh2_pkg and on the murmur2_hash_32 port list.
module mh2_checker
  import mh2_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic [InDataW-1:0] s_axis_tdata_i,
  input logic               s_axis_tlast_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [HashW-1:0]   m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // a full word keeps the input side busy for three multiplier passes
  a_full_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata_i[34]) |=> !s_axis_tready_o ##1 !s_axis_tready_o
                                        ##1 !s_axis_tready_o)
    else $error("input ready during full-word mixing");

  // a short item that is not last changes nothing but the running hash: ready again next cycle
  a_short_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tdata_i[34] && !s_axis_tlast_i) |=> s_axis_tready_o)
    else $error("short non-last item stalled the input");

  // a non-last item never produces a result in the next cycle from an empty output
  a_no_result_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tlast_i && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result produced for a non-last item");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

endmodule

bind murmur2_hash_32 mh2_checker u_mh2_checker (.*);
